// ----- sv/timed_pose_history_buffer_macros.svh -----
// Assertion macros for the pose history buffer checker.
`ifndef TIMED_POSE_HISTORY_BUFFER_MACROS_SVH
`define TIMED_POSE_HISTORY_BUFFER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TPHB_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TPHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/tphb_pkg.sv -----
// Package with operation, status and config register codes and field widths for the pose history buffer.
package tphb_pkg;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_INTERP = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_GAP = 3'd1;
  localparam logic [2:0] ST_EPOCH = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_INTERP = 3'd4;
  localparam logic [2:0] ST_NOT_COVERED = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;

  localparam logic [1:0] REG_CACHE = 2'd0;
  localparam logic [1:0] REG_MAX_GAP = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam int STAMP_W = 63;
  localparam int CFG_W = 40;
  localparam int POS_W = 32;

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic signed [POS_W-1:0] pos_t;
endpackage

// ----- sv/timed_pose_history_buffer.sv -----
// Top level of the timestamped pose history buffer with linear interpolation.
//
//  channel   | handshake       | fields
//  ----------+-----------------+-------------------------------------------
//  command   | start / busy    | operation, stamp, pos_*_in, trans_ok_in
//  result    | done (1 cycle)  | status, pos_*_out, trans_ok_out, entry_count
//  config    | cfg_we          | cfg_index, cfg_data
//
// An add reads the newest stamp, writes the sample and evicts samples older than the
// cache span; an epoch add or one rejected as older stops after the newest-stamp check;
// other rejected adds, an empty-store add and a clear go straight to done. An
// interpolate takes a read and a compare state per binary search step over the single
// stamp memory port, then the serial FRACTION_BITS-bit divider and shared multiplier.
// Reset empties the store at once; the memories keep their contents.
// The receiver cannot stall; done is high for one cycle per command.
module timed_pose_history_buffer #(
  parameter int RING_DEPTH = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] operation,
  input  tphb_pkg::stamp_t stamp,
  input  tphb_pkg::pos_t pos_x_in,
  input  tphb_pkg::pos_t pos_y_in,
  input  tphb_pkg::pos_t pos_z_in,
  input  logic trans_ok_in,
  output logic done,
  output logic [2:0] status,
  output tphb_pkg::pos_t pos_x_out,
  output tphb_pkg::pos_t pos_y_out,
  output tphb_pkg::pos_t pos_z_out,
  output logic trans_ok_out,
  output logic [8:0] entry_count,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [tphb_pkg::CFG_W-1:0] cfg_data
);
  import tphb_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int FW = FRACTION_BITS;
  localparam int DW = STAMP_W + FW;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ADD_RD = 5'd1;
  localparam logic [4:0] S_ADD_CHK = 5'd2;
  localparam logic [4:0] S_EV_RDN = 5'd3;
  localparam logic [4:0] S_EV_RDO = 5'd4;
  localparam logic [4:0] S_EV_CHK = 5'd5;
  localparam logic [4:0] S_Q_RDO = 5'd6;
  localparam logic [4:0] S_Q_RDN = 5'd7;
  localparam logic [4:0] S_Q_CHK = 5'd8;
  localparam logic [4:0] S_B_RD = 5'd9;
  localparam logic [4:0] S_B_CMP = 5'd11;
  localparam logic [4:0] S_HIT_RD = 5'd12;
  localparam logic [4:0] S_HIT_CHK = 5'd13;
  localparam logic [4:0] S_LO_RD = 5'd14;
  localparam logic [4:0] S_LO_CHK = 5'd15;
  localparam logic [4:0] S_DIV = 5'd16;
  localparam logic [4:0] S_MUL = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  logic [CFG_W-1:0] cache_span, max_gap_ns, reset_threshold_ns;

  stamp_t ring_stamps [RING_DEPTH];
  logic [3*POS_W:0] ring_data [RING_DEPTH];

  logic [AW-1:0] oldest_slot;
  logic [CW-1:0] held_count;

  logic [4:0] state;
  stamp_t stamp_q;
  pos_t px_q, py_q, pz_q;
  logic ok_q;

  logic st_we, d_we;
  logic [AW-1:0] st_waddr, st_raddr, d_raddr;
  stamp_t st_rdata;
  logic [3*POS_W:0] d_rdata;

  stamp_t newest_q, oldest_q, lower_q;
  logic [3*POS_W:0] lower_d;
  logic [CW-1:0] lo, hi;
  logic gap_q;

  logic [DW-1:0] rem_q, gapv_q;
  logic [FW-1:0] frac_q;
  logic [$clog2(FW+1)-1:0] cnt_q;
  logic [1:0] axis_q;

  logic [2:0] status_r;
  pos_t rx, ry, rz;
  logic rok;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] lg);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(lg);
    if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
    return AW'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (st_we) ring_stamps[st_waddr] <= stamp_q;
    if (d_we) ring_data[st_waddr] <= {ok_q, pz_q, py_q, px_q};
    st_rdata <= ring_stamps[st_raddr];
    d_rdata <= ring_data[d_raddr];
  end

  logic [CW-1:0] mid;
  assign mid = lo + ((hi - lo) >> 1);

  // Shared multiplier with rounding, one axis per cycle.
  logic signed [POS_W:0] dlt;
  logic signed [POS_W+FW+1:0] prod;
  pos_t lo_ax, hi_ax;
  always_comb begin
    unique case (axis_q)
      2'd0: begin lo_ax = lower_d[POS_W-1:0]; hi_ax = d_rdata[POS_W-1:0]; end
      2'd1: begin
        lo_ax = lower_d[2*POS_W-1:POS_W]; hi_ax = d_rdata[2*POS_W-1:POS_W];
      end
      default: begin
        lo_ax = lower_d[3*POS_W-1:2*POS_W]; hi_ax = d_rdata[3*POS_W-1:2*POS_W];
      end
    endcase
    dlt = (POS_W+1)'(hi_ax) - (POS_W+1)'(lo_ax);
    prod = (POS_W+FW+2)'(dlt) * $signed({2'b00, frac_q})
           + (POS_W+FW+2)'(1 << (FW-1));
  end
  pos_t lerp;
  assign lerp = lo_ax + POS_W'(prod >>> FW);

  logic [DW-1:0] rem_sh;
  assign rem_sh = {rem_q[DW-2:0], 1'b0};

  always_comb begin
    st_raddr = slot(oldest_slot, held_count - CW'(1));
    d_raddr = st_raddr;
    unique case (state)
      S_EV_RDO, S_Q_RDO: st_raddr = oldest_slot;
      S_B_RD: st_raddr = slot(oldest_slot, mid);
      S_HIT_RD: begin st_raddr = slot(oldest_slot, lo); d_raddr = st_raddr; end
      S_LO_RD: begin
        st_raddr = slot(oldest_slot, lo - CW'(1)); d_raddr = st_raddr;
      end
      S_DIV, S_MUL: d_raddr = slot(oldest_slot, lo);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    st_we <= 1'b0;
    d_we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      cache_span <= 40'd2000000000;
      max_gap_ns <= 40'd50000000;
      reset_threshold_ns <= 40'd1000000000;
      oldest_slot <= '0;
      held_count <= '0;
      state <= S_IDLE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CACHE: cache_span <= cfg_data;
          REG_MAX_GAP: max_gap_ns <= cfg_data;
          REG_THRESHOLD: reset_threshold_ns <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (start) begin
          stamp_q <= stamp;
          px_q <= pos_x_in; py_q <= pos_y_in; pz_q <= pos_z_in;
          ok_q <= trans_ok_in;
          rx <= '0; ry <= '0; rz <= '0; rok <= 1'b0;
          gap_q <= 1'b0;
          priority case (operation)
            OP_ADD: begin
              if (stamp == '0 || cache_span == '0 || max_gap_ns == '0) begin
                status_r <= ST_REJECTED; state <= S_DONE;
              end else if (held_count == '0) begin
                oldest_slot <= '0; held_count <= CW'(1);
                st_waddr <= '0; st_we <= 1'b1; d_we <= 1'b1;
                status_r <= ST_ACCEPTED; state <= S_DONE;
              end else state <= S_ADD_RD;
            end
            OP_INTERP: begin
              if (held_count == '0) begin
                status_r <= ST_NOT_COVERED; state <= S_DONE;
              end else state <= S_Q_RDO;
            end
            OP_CLEAR: begin
              held_count <= '0; oldest_slot <= '0;
              status_r <= ST_CLEARED; state <= S_DONE;
            end
            default: begin status_r <= ST_REJECTED; state <= S_DONE; end
          endcase
        end
        S_ADD_RD: state <= S_ADD_CHK;
        S_ADD_CHK: begin
          if (stamp_q < st_rdata) begin
            if ((st_rdata - stamp_q) > STAMP_W'(reset_threshold_ns)) begin
              oldest_slot <= '0; held_count <= CW'(1);
              st_waddr <= '0; st_we <= 1'b1; d_we <= 1'b1;
              status_r <= ST_EPOCH;
            end else status_r <= ST_REJECTED;
            state <= S_DONE;
          end else begin
            gap_q <= (stamp_q - st_rdata) > STAMP_W'(max_gap_ns);
            st_we <= 1'b1; d_we <= 1'b1;
            if (stamp_q == st_rdata) begin
              st_waddr <= slot(oldest_slot, held_count - CW'(1));
            end else if (held_count >= CW'(RING_DEPTH)) begin
              st_waddr <= oldest_slot;
              oldest_slot <= slot(oldest_slot, CW'(1));
            end else begin
              st_waddr <= slot(oldest_slot, held_count);
              held_count <= held_count + CW'(1);
            end
            state <= S_EV_RDN;
          end
        end
        S_EV_RDN: state <= S_EV_RDO;
        S_EV_RDO: begin newest_q <= stamp_q; state <= S_EV_CHK; end
        S_EV_CHK: begin
          if (held_count > CW'(1) &&
              (newest_q - st_rdata) > STAMP_W'(cache_span)) begin
            oldest_slot <= slot(oldest_slot, CW'(1));
            held_count <= held_count - CW'(1);
            state <= S_EV_RDO;
          end else begin
            status_r <= gap_q ? ST_GAP : ST_ACCEPTED; state <= S_DONE;
          end
        end
        S_Q_RDO: state <= S_Q_RDN;
        S_Q_RDN: begin oldest_q <= st_rdata; state <= S_Q_CHK; end
        S_Q_CHK: begin
          if (stamp_q < oldest_q || stamp_q > st_rdata) begin
            status_r <= ST_NOT_COVERED; state <= S_DONE;
          end else begin
            lo <= '0; hi <= held_count; state <= S_B_RD;
          end
        end
        S_B_RD: state <= S_B_CMP;
        S_B_CMP: begin
          if (st_rdata < stamp_q) lo <= mid + CW'(1);
          else hi <= mid;
          state <= S_B_RD;
          if (st_rdata < stamp_q ? (mid + CW'(1) >= hi) : (lo >= mid))
            state <= S_HIT_RD;
        end
        S_HIT_RD: state <= S_HIT_CHK;
        S_HIT_CHK: begin
          if (st_rdata == stamp_q) begin
            rx <= d_rdata[POS_W-1:0]; ry <= d_rdata[2*POS_W-1:POS_W];
            rz <= d_rdata[3*POS_W-1:2*POS_W]; rok <= d_rdata[3*POS_W];
            status_r <= ST_INTERP; state <= S_DONE;
          end else begin
            lower_q <= st_rdata; state <= S_LO_RD;
          end
        end
        S_LO_RD: state <= S_LO_CHK;
        S_LO_CHK: begin
          lower_d <= d_rdata;
          if (lower_q - st_rdata > STAMP_W'(max_gap_ns)) begin
            status_r <= ST_NOT_COVERED; state <= S_DONE;
          end else begin
            gapv_q <= DW'(lower_q - st_rdata);
            rem_q <= DW'(stamp_q - st_rdata);
            lower_q <= st_rdata;
            frac_q <= '0; cnt_q <= '0; state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= gapv_q) begin
            rem_q <= rem_sh - gapv_q; frac_q <= {frac_q[FW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh; frac_q <= {frac_q[FW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + ($clog2(FW+1))'(1);
          if (cnt_q == ($clog2(FW+1))'(FW-1)) begin
            axis_q <= 2'd0; state <= S_MUL;
          end
        end
        S_MUL: begin
          unique case (axis_q)
            2'd0: rx <= lerp;
            2'd1: ry <= lerp;
            default: begin
              rz <= lerp; rok <= lower_d[3*POS_W] & d_rdata[3*POS_W];
              status_r <= ST_INTERP; state <= S_DONE;
            end
          endcase
          axis_q <= axis_q + 2'd1;
        end
        S_DONE: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign status = status_r;
  assign pos_x_out = rx;
  assign pos_y_out = ry;
  assign pos_z_out = rz;
  assign trans_ok_out = rok;
  assign entry_count = 9'(held_count);
endmodule

// ----- sv/tphb_checker.sv -----
// Port-level checker for the pose history buffer, bound to the top level.
`include "timed_pose_history_buffer_macros.svh"
module tphb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [2:0] status,
  input logic [31:0] pos_x_out,
  input logic trans_ok_out,
  input logic [8:0] entry_count
);
  import tphb_pkg::*;
  `TPHB_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `TPHB_ASSERT(a_done_idle, done, !busy)
  `TPHB_ASSERT(a_clear_empty, done && status == ST_CLEARED, entry_count == 9'd0)
  `TPHB_ASSERT(a_zero_pos, done && status != ST_INTERP, pos_x_out == '0 && !trans_ok_out)
endmodule

bind timed_pose_history_buffer tphb_checker u_tphb_checker (.*);
